@@ design/srd_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// srd_pkg
// Shared types, constants and helpers of the shared memory race detector.
// ---------------------------------------------------------------------------
package srd_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int THREAD_BITS = 16;
   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int OFF_BITS    = 12;
   localparam int GROUP_BITS  = 16;
   localparam int ID_BITS     = 16;
   localparam int CMP_BITS    = ((ADDR_BITS > OFF_BITS) ? ADDR_BITS : OFF_BITS) + 1;
   localparam int ENTRY_BITS  = THREAD_BITS + GROUP_BITS + 4;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_LOCAL  = 2'd2,
      OP_GLOBAL = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CHECK,
      ST_LOC_READ,
      ST_LOC_WRITE,
      ST_GLOBAL,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [1:0]          operation;
      logic [ID_BITS-1:0]  thread_id;
      logic [ID_BITS-1:0]  group_id;
      logic [OFF_BITS-1:0] byte_offset;
   } req_type;

   typedef struct packed {
      logic               race_found;
      logic               race_kind;
      logic [ID_BITS-1:0] first_thread;
      logic [ID_BITS-1:0] second_thread;
   } rsp_type;

   typedef struct packed {
      logic [THREAD_BITS-1:0] thread;
      logic [GROUP_BITS-1:0]  group;
      logic                   read;
      logic                   write;
      logic                   many_read;
      logic                   group_many_read;
   } entry_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      entry_type            data;
   } tbl_wr_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
   } tbl_rd_type;

   typedef struct packed {
      logic      update;
      entry_type entry;
      rsp_type   rsp;
   } chk_result_type;

   function automatic logic offset_in_range(input logic [OFF_BITS-1:0] off);
      logic [CMP_BITS-1:0] off_ext;
      off_ext = CMP_BITS'(off);
      return off_ext < CMP_BITS'(TABLE_DEPTH);
   endfunction

   function automatic logic [ADDR_BITS-1:0] offset_addr(input logic [OFF_BITS-1:0] off);
      logic [CMP_BITS-1:0] off_ext;
      off_ext = CMP_BITS'(off);
      return off_ext[ADDR_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

@@ design/srd_table.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// srd_table
// Shadow table: one write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module srd_table
   import srd_pkg::*;
(
   input  wire logic       clock,
   input  wire tbl_wr_type wr,
   input  wire tbl_rd_type rd,
   output entry_type       rd_data
);

   logic [ENTRY_BITS-1:0] mem [TABLE_DEPTH];
   logic [ENTRY_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      // Read data holds while no read is issued, so a stalled check sees it.
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = entry_type'(rd_data_ff);

endmodule
`default_nettype wire

@@ design/srd_check.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// srd_check
// Race check of one access against its shadow entry, and the updated entry.
// ---------------------------------------------------------------------------
module srd_check
   import srd_pkg::*;
(
   input  wire req_type   req,
   input  wire entry_type entry,
   output chk_result_type result
);

   logic [THREAD_BITS-1:0] thr;
   logic                   active;
   logic                   match;
   logic                   is_write;

   assign thr      = THREAD_BITS'(req.thread_id);
   assign active   = (thr != '0) && offset_in_range(req.byte_offset);
   assign match    = (entry.group == req.group_id) &&
                     ((entry.thread == thr) || (entry.thread == '0));
   assign is_write = (op_type'(req.operation) == OP_WRITE);

   always_comb begin
      result        = '0;
      result.entry  = entry;
      if (active) begin
         if (!is_write) begin
            if (entry.write && !match) begin
               result.rsp.race_found    = 1'b1;
               result.rsp.race_kind     = 1'b0;
               result.rsp.first_thread  = ID_BITS'(thr);
               result.rsp.second_thread = ID_BITS'(entry.thread);
            end else begin
               result.update = 1'b1;
               if (entry.read) begin
                  if ((entry.thread != '0) && (entry.thread != thr)) begin
                     result.entry.many_read = 1'b1;
                  end
                  if (entry.group != req.group_id) begin
                     result.entry.group_many_read = 1'b1;
                  end
               end
               result.entry.thread = thr;
               result.entry.group  = req.group_id;
               result.entry.read   = 1'b1;
            end
         end else begin
            if (entry.many_read || entry.group_many_read ||
                ((entry.read || entry.write) && !match)) begin
               result.rsp.race_found    = 1'b1;
               result.rsp.race_kind     = !entry.read;
               result.rsp.first_thread  = ID_BITS'(entry.thread);
               result.rsp.second_thread = ID_BITS'(thr);
            end else begin
               result.update       = 1'b1;
               result.entry.thread = thr;
               result.entry.group  = req.group_id;
               result.entry.write  = 1'b1;
            end
         end
      end
   end

endmodule
`default_nettype wire

@@ design/shared_memory_race_detector.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// shared_memory_race_detector
// Shadow-table data race detector for one tracked object.
// ---------------------------------------------------------------------------
// Usage: a request carries an operation (read, write, local barrier reset,
// global reset), a thread, a work group and a byte offset. Every request
// gives exactly one response on the rsp_ channel, race_found being set when
// a read or write conflicts with the history kept in the shadow table.
// Reads and writes do one read-modify-write of their table entry: the
// table read data is registered, then the check result is loaded into the
// output register; a new request is taken only once the last one has left
// the check state, which waits while the output register cannot be freed.
// A local barrier reset walks the table with a read and a write per entry;
// a global reset writes zero to each entry.
// After reset the block runs a clearing pass over all TABLE_DEPTH entries
// with req_ready low. A response that waits on rsp_ready sits in the output
// register; the next request is still taken, and it holds in its final
// cycle until the output register is free.
// ---------------------------------------------------------------------------
module shared_memory_race_detector
   import srd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   state_type            state_ff, state_in;
   logic [ADDR_BITS-1:0] cnt_ff, cnt_in;
   req_type              req_ff, req_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic           accept;
   logic           out_free;
   logic           last;
   logic           rsp_load;
   rsp_type        rsp_next;
   tbl_wr_type     tbl_wr;
   tbl_rd_type     tbl_rd;
   entry_type      rd_entry;
   entry_type      local_entry;
   chk_result_type chk;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last     = (cnt_ff == ADDR_BITS'(TABLE_DEPTH - 1));

   srd_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd      (tbl_rd),
      .rd_data (rd_entry)
   );

   srd_check u_check (
      .req    (req_ff),
      .entry  (rd_entry),
      .result (chk)
   );

   always_comb begin
      local_entry           = rd_entry;
      local_entry.thread    = '0;
      local_entry.many_read = 1'b0;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (op_type'(req_data.operation)) inside
                  OP_READ, OP_WRITE: state_in = ST_CHECK;
                  OP_LOCAL:          state_in = ST_LOC_READ;
                  OP_GLOBAL:         state_in = ST_GLOBAL;
                  default:           state_in = ST_IDLE;
               endcase
            end
         end
         ST_CHECK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_LOC_READ: begin
            state_in = ST_LOC_WRITE;
         end
         ST_LOC_WRITE: begin
            state_in = last ? ST_REPLY : ST_LOC_READ;
         end
         ST_GLOBAL: begin
            if (last) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready   = 1'b0;
      tbl_rd      = '0;
      tbl_wr      = '0;
      rsp_load    = 1'b0;
      rsp_next    = '0;
      cnt_in      = cnt_ff;
      unique case (state_ff) inside
         ST_INIT, ST_GLOBAL: begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = cnt_ff;
            cnt_in      = last ? '0 : cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            tbl_rd.en   = accept;
            tbl_rd.addr = offset_addr(req_data.byte_offset);
         end
         ST_CHECK: begin
            tbl_wr.en   = out_free && chk.update;
            tbl_wr.addr = offset_addr(req_ff.byte_offset);
            tbl_wr.data = chk.entry;
            rsp_load    = out_free;
            rsp_next    = chk.rsp;
         end
         ST_LOC_READ: begin
            tbl_rd.en   = 1'b1;
            tbl_rd.addr = cnt_ff;
         end
         ST_LOC_WRITE: begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = cnt_ff;
            tbl_wr.data = local_entry;
            cnt_in      = last ? '0 : cnt_ff + 1'b1;
         end
         ST_REPLY: begin
            rsp_load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_in       = accept ? req_data : req_ff;
   assign rsp_data_in  = rsp_load ? rsp_next : rsp_data_ff;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A response without a race carries no thread ids and no kind.
   a_quiet_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.race_found |->
         !rsp_data_ff.race_kind && (rsp_data_ff.first_thread == '0) &&
         (rsp_data_ff.second_thread == '0))
      else $error("response without race carries nonzero fields");

   // The table is never written while the block waits for a request.
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !tbl_wr.en)
      else $error("table written while idle");

   // A detected race leaves its entry untouched.
   a_race_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) && chk.rsp.race_found |-> !tbl_wr.en)
      else $error("entry written on a race");

   // Each local sweep write follows the read of the same entry.
   a_local_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOC_WRITE |->
         ($past(state_ff) == ST_LOC_READ) && $stable(cnt_ff))
      else $error("local sweep write without its read");

endmodule
`default_nettype wire

@@ test/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the shared memory race detector. Requests go in
// over a valid/ready channel, and each transfer is run through a behavioral
// shadow table that predicts the race verdict. Every response is compared
// field by field with the oldest pending verdict. The run has directed race
// scenarios, a long response stall, a full drain and three random phases
// with different idle patterns.
// ---------------------------------------------------------------------------
module tb
   import srd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [THREAD_BITS-1:0] owner;
      logic [GROUP_BITS-1:0]  grp;
      logic                   rd;
      logic                   wr;
      logic                   multi_rd;
      logic                   multi_grp_rd;
   } shadow_rec_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   shadow_rec_type shadow [TABLE_DEPTH];
   rsp_type   expected_verdicts [$];
   int        mismatch_count = 0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        hold_request = 0;
   int        hold_left = 0;
   logic [OFF_BITS-1:0] hot_offsets [6] = '{12'h000, 12'h001, 12'h002, 12'h040,
                                            12'h7ff, 12'hfff};

   shared_memory_race_detector u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(20_000_000);
      $display("[shared_memory_race_detector] ERROR");
      $finish;
   end

   // Works out the verdict of one request and applies it to the shadow table.
   function automatic rsp_type predict_access(input req_type r);
      rsp_type                verdict;
      shadow_rec_type         e;
      logic [THREAD_BITS-1:0] thr;
      logic [GROUP_BITS-1:0]  grp;
      logic                   same;
      int                     idx;
      verdict = '0;
      thr = r.thread_id[THREAD_BITS-1:0];
      grp = r.group_id;
      idx = int'(r.byte_offset);
      case (op_type'(r.operation))
         OP_GLOBAL: begin
            foreach (shadow[i]) shadow[i] = '0;
         end
         OP_LOCAL: begin
            foreach (shadow[i]) begin
               shadow[i].owner    = '0;
               shadow[i].multi_rd = 1'b0;
            end
         end
         default: begin
            if (thr != '0 && idx < TABLE_DEPTH) begin
               e = shadow[idx];
               same = (e.grp == grp) && (e.owner == thr || e.owner == '0);
               if (op_type'(r.operation) == OP_READ) begin
                  if (e.wr && !same) begin
                     verdict.race_found    = 1'b1;
                     verdict.race_kind     = 1'b0;
                     verdict.first_thread  = ID_BITS'(thr);
                     verdict.second_thread = ID_BITS'(e.owner);
                  end else begin
                     if (e.rd) begin
                        if (e.owner != '0 && e.owner != thr) e.multi_rd = 1'b1;
                        if (e.grp != grp) e.multi_grp_rd = 1'b1;
                     end
                     e.owner = thr;
                     e.grp   = grp;
                     e.rd    = 1'b1;
                  end
               end else begin
                  if (e.multi_rd || e.multi_grp_rd || ((e.rd || e.wr) && !same)) begin
                     verdict.race_found    = 1'b1;
                     verdict.race_kind     = !e.rd;
                     verdict.first_thread  = ID_BITS'(e.owner);
                     verdict.second_thread = ID_BITS'(thr);
                  end else begin
                     e.owner = thr;
                     e.grp   = grp;
                     e.wr    = 1'b1;
                  end
               end
               shadow[idx] = e;
            end
         end
      endcase
      return verdict;
   endfunction

   function automatic req_type make_request(input op_type op, input int thr, input int grp,
                                            input int off);
      req_type r;
      r.operation   = op;
      r.thread_id   = ID_BITS'(thr);
      r.group_id    = ID_BITS'(grp);
      r.byte_offset = OFF_BITS'(off);
      return r;
   endfunction

   // Mostly a few threads and groups hitting a few hot bytes, so that entries
   // build up history; the rest spreads over every field value.
   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      if ($urandom_range(0, 9) == 0)
         r.thread_id = '0;
      else if ($urandom_range(0, 9) < 7)
         r.thread_id = ID_BITS'($urandom_range(1, 3));
      else
         r.thread_id = ID_BITS'($urandom);
      if ($urandom_range(0, 9) < 7)
         r.group_id = ID_BITS'($urandom_range(0, 1));
      else
         r.group_id = ID_BITS'($urandom);
      if ($urandom_range(0, 9) < 7)
         r.byte_offset = hot_offsets[$urandom_range(0, 5)];
      else
         r.byte_offset = OFF_BITS'($urandom);
      pick = $urandom_range(0, 199);
      if (pick < 3)
         r.operation = OP_LOCAL;
      else if (pick < 6)
         r.operation = OP_GLOBAL;
      else if (pick < 103)
         r.operation = OP_READ;
      else
         r.operation = OP_WRITE;
      return r;
   endfunction

   // Offers one request and records its verdict once the transfer happens.
   task automatic send_request(input req_type r);
      int      gap;
      rsp_type verdict;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_ready !== 1'b1);
      verdict = predict_access(r);
      expected_verdicts.insert(expected_verdicts.size(), verdict);
   endtask

   task automatic stop_requests();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_for_drain();
      while (expected_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_races();
      send_request(make_request(OP_READ, 0, 1, 0));
      send_request(make_request(OP_WRITE, 1, 1, 0));
      send_request(make_request(OP_READ, 1, 1, 0));
      send_request(make_request(OP_READ, 2, 1, 0));
      send_request(make_request(OP_WRITE, 2, 1, 0));
      send_request(make_request(OP_LOCAL, 0, 0, 0));
      // After the barrier the stored thread is gone, so any thread of the
      // same group matches again.
      send_request(make_request(OP_READ, 2, 1, 0));
      send_request(make_request(OP_WRITE, 3, 2, 4095));
      send_request(make_request(OP_WRITE, 4, 2, 4095));
      send_request(make_request(OP_READ, 5, 3, 100));
      send_request(make_request(OP_READ, 6, 3, 100));
      send_request(make_request(OP_WRITE, 6, 3, 100));
      send_request(make_request(OP_READ, 7, 4, 200));
      send_request(make_request(OP_READ, 7, 5, 200));
      // A barrier keeps the many-groups flag, so the write still races.
      send_request(make_request(OP_LOCAL, 9, 9, 9));
      send_request(make_request(OP_WRITE, 7, 5, 200));
      send_request(make_request(OP_GLOBAL, 0, 0, 0));
      send_request(make_request(OP_WRITE, 7, 5, 200));
      send_request(make_request(OP_READ, 16'hffff, 16'hffff, 12'hfff));
      send_request(make_request(OP_WRITE, 16'hffff, 0, 12'hfff));
      send_request(make_request(OP_WRITE, 0, 16'hffff, 12'hfff));
      stop_requests();
   endtask

   task automatic test_response_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 300;
      repeat (24) send_request(random_request());
      stop_requests();
   endtask

   task automatic test_drain_pause();
      wait_for_drain();
      repeat (10) send_request(random_request());
      stop_requests();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) send_request(random_request());
      stop_requests();
   endtask

   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic check_field(input string name, input logic [ID_BITS-1:0] want,
                              input logic [ID_BITS-1:0] got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: response with none expected, expected nothing actual %h",
                     $time, rsp_data);
            mismatch_count++;
         end else begin
            want = expected_verdicts.pop_front();
            check_field("race_found", ID_BITS'(want.race_found),
                        ID_BITS'(rsp_data.race_found));
            check_field("race_kind", ID_BITS'(want.race_kind),
                        ID_BITS'(rsp_data.race_kind));
            check_field("first_thread", want.first_thread, rsp_data.first_thread);
            check_field("second_thread", want.second_thread, rsp_data.second_thread);
         end
      end
   end

   initial begin
      foreach (shadow[i]) shadow[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 11;
      recv_idle_pct = 72;
      test_directed_races();
      test_response_stall();
      test_drain_pause();
      test_random_traffic(11, 72, 465);
      test_random_traffic(72, 11, 465);
      test_random_traffic(0, 0, 465);
      wait_for_drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("[shared_memory_race_detector] OK");
      else
         $display("[shared_memory_race_detector] ERROR");
      $finish;
   end

endmodule
